/* rtl/core/clsr_pkg.sv */
// Shared constants, control-word types and the microprogram ROM for the
// combined LCG shuffle generator. No dependencies.

package clsr_pkg;

    localparam int DW = 31;

    localparam logic [31:0] MOD1       = 32'd2147483563;
    localparam logic [31:0] MOD2       = 32'd2147483399;
    localparam logic [15:0] MUL1       = 16'd40014;
    localparam logic [15:0] MUL2       = 16'd40692;
    localparam logic [31:0] SPAN1      = 32'd2147483562;
    localparam logic [31:0] SAMPLE_MAX = 32'd2147483305;
    localparam logic [30:0] GEN2_INIT  = 31'd123456789;
    localparam int          WARMUP_EXTRA = 8;

    localparam int STEP_W = 4;

    // Microprogram addresses.
    localparam logic [STEP_W-1:0] S_IDLE = 4'd0;
    localparam logic [STEP_W-1:0] S_DISP = 4'd1;
    localparam logic [STEP_W-1:0] S_SEED = 4'd2;
    localparam logic [STEP_W-1:0] S_WGO  = 4'd3;
    localparam logic [STEP_W-1:0] S_WW1  = 4'd4;
    localparam logic [STEP_W-1:0] S_WW2  = 4'd5;
    localparam logic [STEP_W-1:0] S_WWB  = 4'd6;
    localparam logic [STEP_W-1:0] S_DRAW = 4'd7;
    localparam logic [STEP_W-1:0] S_IDXQ = 4'd8;
    localparam logic [STEP_W-1:0] S_IDXF = 4'd9;
    localparam logic [STEP_W-1:0] S_WB   = 4'd10;
    localparam logic [STEP_W-1:0] S_DIFF = 4'd11;
    localparam logic [STEP_W-1:0] S_OUT  = 4'd12;

    typedef enum logic [2:0] {
        C_NEXT,
        C_GOTO,
        C_WAIT_IN,
        C_IF_DRAW,
        C_IF_CNT,
        C_WAIT_OUT
    } t_cond;

    typedef struct packed {
        t_cond             cond;
        logic [STEP_W-1:0] target;
        logic              in_rdy;
        logic              ld_seed;
        logic              go1;
        logic              go2;
        logic              wb1;
        logic              wb2;
        logic              warm_wr;
        logic              cnt_dec;
        logic              idx_mul;
        logic              idx_q;
        logic              idx_fix;
        logic              tbl_rd;
        logic              draw_wr;
        logic              diff;
        logic              out_ld;
    } t_uword;

    typedef struct packed {
        logic in_fire;
        logic draw;
        logic cnt_nz;
        logic out_free;
    } t_seq_flags;

    function automatic t_uword ucode_rom(input logic [STEP_W-1:0] addr);
        t_uword w;
        w      = '0;
        w.cond = C_NEXT;
        case (addr)
            S_IDLE: begin
                w.in_rdy = 1'b1;
                w.cond   = C_WAIT_IN;
            end
            S_DISP: begin
                w.cond   = C_IF_DRAW;
                w.target = S_DRAW;
            end
            S_SEED: w.ld_seed = 1'b1;
            S_WGO:  w.go1     = 1'b1;
            S_WW1:  w.cond    = C_NEXT;
            S_WW2:  w.cond    = C_NEXT;
            S_WWB: begin
                w.wb1     = 1'b1;
                w.warm_wr = 1'b1;
                w.cnt_dec = 1'b1;
                w.cond    = C_IF_CNT;
                w.target  = S_WGO;
            end
            S_DRAW: begin
                w.go1     = 1'b1;
                w.go2     = 1'b1;
                w.idx_mul = 1'b1;
            end
            S_IDXQ: w.idx_q   = 1'b1;
            S_IDXF: w.idx_fix = 1'b1;
            S_WB: begin
                w.wb1    = 1'b1;
                w.wb2    = 1'b1;
                w.tbl_rd = 1'b1;
            end
            S_DIFF: begin
                w.draw_wr = 1'b1;
                w.diff    = 1'b1;
            end
            S_OUT: begin
                w.out_ld = 1'b1;
                w.cond   = C_WAIT_OUT;
                w.target = S_IDLE;
            end
            default: begin
                w.cond   = C_GOTO;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* rtl/core/clsr_mcg.sv */
// Multiplicative congruential step x*MUL mod MODULUS as a three-stage pipeline.
// Depends on clsr_pkg. The product, folded sum and reduced result are registered in turn.

module clsr_mcg
    import clsr_pkg::*;
#(
    parameter logic [31:0] MODULUS = MOD1,
    parameter logic [15:0] MUL     = MUL1
) (
    input  logic          i_clk,
    input  logic          i_go,
    input  logic [DW-1:0] i_x,
    output logic [DW-1:0] o_y
);

    localparam int P_W = DW + 16;
    // The modulus is 2^31 - FOLD, so the high part folds back times FOLD.
    localparam logic [7:0] FOLD = 8'((33'd1 << 31) - 33'(MODULUS));

    logic [P_W-1:0] r_p;
    logic [31:0]    r_s;
    logic [DW-1:0]  r_y;

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_p <= P_W'(i_x) * P_W'(MUL);
        end
        r_s <= {1'b0, r_p[DW-1:0]} + 32'(r_p[P_W-1:DW]) * 32'(FOLD);
        // The folded sum stays below twice the modulus.
        r_y <= (r_s >= MODULUS) ? DW'(r_s - MODULUS) : r_s[DW-1:0];
    end

    assign o_y = r_y;

endmodule

/* rtl/core/clsr_table.sv */
// Shuffle table memory with a registered read port and per-entry valid bits.
// Depends on clsr_pkg. Entries never written read as zero.

module clsr_table
    import clsr_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int IDX_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  logic [DW-1:0]    i_wdata,
    input  logic             i_re,
    input  logic [IDX_W-1:0] i_raddr,
    output logic [DW-1:0]    o_rdata
);

    logic [DW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [DW-1:0]    r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_valid[i_raddr] ? r_mem[i_raddr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/clsr_ucode.sv */
// Microprogram sequencer: step counter, control ROM and jump logic.
// Depends on clsr_pkg for the ROM function and control-word types.

module clsr_ucode
    import clsr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_seq_flags i_flags,
    output t_uword     o_ctrl
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            ctrl;

    assign ctrl = ucode_rom(r_step);

    always_comb begin
        n_step = r_step + 1'b1;
        case (ctrl.cond)
            C_NEXT:     n_step = r_step + 1'b1;
            C_GOTO:     n_step = ctrl.target;
            C_WAIT_IN:  n_step = i_flags.in_fire ? r_step + 1'b1 : r_step;
            C_IF_DRAW:  n_step = i_flags.draw ? ctrl.target : r_step + 1'b1;
            C_IF_CNT:   n_step = i_flags.cnt_nz ? ctrl.target : r_step + 1'b1;
            C_WAIT_OUT: n_step = i_flags.out_free ? ctrl.target : r_step;
            default:    n_step = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl = ctrl;

endmodule

/* rtl/core/combined_lcg_shuffle_rng_top.sv */
// Top level of the combined two-generator random source with shuffle table.
// Depends on clsr_pkg, clsr_ucode, clsr_mcg and clsr_table.
//
//  Channel  Dir  Signals                          Contents
//  s_axis   in   tvalid tready tdata[31:0] tuser  tdata: seed; tuser: operation
//  m_axis   out  tvalid tready tdata[31:0]        tdata: sample
//
// One input transfer at a time. A draw walks the dispatch, draw, index quotient,
// index fix, write-back, difference and output steps, then returns to idle.
// A reseed first runs TABLE_DEPTH + 8 warm-up steps of the first generator,
// each walking the modular multiply pipeline once, and then draws.
// Reset clears generators to their start values and the table to zeros.
// A stalled result is held in the output register; the sequencer waits at its
// last step until that register frees, and takes new input only when idle.

module combined_lcg_shuffle_rng_top
    import clsr_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [30:0] seed, [31] zero
    input  logic [0:0]  s_axis_tuser,   // [0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [30:0] sample, [31] zero
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + WARMUP_EXTRA);
    localparam logic [31:0] IDX_DIV = 32'(32'd1 + (MOD1 - 32'd1) / 32'(TABLE_DEPTH));
    // Reciprocal of the index divisor, scaled by 2^56; the quotient estimate
    // is at most one low and is corrected by one compare.
    localparam int SH = 56;
    localparam logic [31:0] RECIP = 32'((64'd1 << SH) / 64'(IDX_DIV));
    localparam int QP_W = DW + 32;
    localparam int Q_W  = QP_W - SH;

    t_uword     ctrl;
    t_seq_flags flags;

    logic              r_op;
    logic [DW-1:0]     r_seed;
    logic [DW-1:0]     r_g1;
    logic [DW-1:0]     r_g2;
    logic [DW-1:0]     r_last;
    logic [CNT_W-1:0]  r_cnt;
    logic [QP_W-1:0]   r_qp;
    logic [Q_W-1:0]    r_q0;
    logic [DW-1:0]     r_qd;
    logic [IDX_W-1:0]  r_idx;
    logic [31:0]       r_negc;
    logic [DW-1:0]     r_sample;
    logic              r_out_valid;

    logic [DW-1:0]     y1;
    logic [DW-1:0]     y2;
    logic [DW-1:0]     ent;
    logic              in_fire;
    logic              out_free;
    logic              warm_hit;
    logic              tbl_we;
    logic [IDX_W-1:0]  tbl_waddr;
    logic [DW-1:0]     tbl_wdata;
    logic [Q_W-1:0]    q0;
    logic [DW-1:0]     rem;
    logic [Q_W-1:0]    q;
    logic signed [32:0] diff_a;
    logic signed [32:0] diff_b;
    logic signed [32:0] diff_s;
    logic [DW-1:0]     diff_c;

    clsr_ucode u_ucode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

    clsr_mcg #(.MODULUS(MOD1), .MUL(MUL1)) u_mcg1 (
        .i_clk (i_clk),
        .i_go  (ctrl.go1),
        .i_x   (r_g1),
        .o_y   (y1)
    );

    clsr_mcg #(.MODULUS(MOD2), .MUL(MUL2)) u_mcg2 (
        .i_clk (i_clk),
        .i_go  (ctrl.go2),
        .i_x   (r_g2),
        .o_y   (y2)
    );

    clsr_table #(.DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (ctrl.tbl_rd),
        .i_raddr (r_idx),
        .o_rdata (ent)
    );

    assign s_axis_tready = ctrl.in_rdy && i_rst_n;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    assign flags.in_fire  = in_fire;
    assign flags.draw     = !r_op;
    assign flags.cnt_nz   = (r_cnt != '0);
    assign flags.out_free = out_free;

    // Only the last TABLE_DEPTH warm-up steps land in the table.
    assign warm_hit  = ctrl.warm_wr && (32'(r_cnt) < 32'(TABLE_DEPTH));
    assign tbl_we    = warm_hit || ctrl.draw_wr;
    assign tbl_waddr = ctrl.draw_wr ? r_idx : r_cnt[IDX_W-1:0];
    assign tbl_wdata = ctrl.draw_wr ? r_g1 : y1;

    assign q0  = r_qp[QP_W-1:SH];
    assign rem = r_last - r_qd;
    assign q   = r_q0 + Q_W'({31'd0, ({1'b0, rem} >= IDX_DIV)});

    always_comb begin
        diff_a = $signed({2'b00, ent}) - $signed({2'b00, r_g2});
        diff_b = $signed({2'b00, ent} + {1'b0, r_negc});
        diff_s = (diff_a > 33'sd0) ? diff_a : diff_b;
        if (diff_s < 33'sd1) begin
            diff_c = DW'(1);
        end else if (diff_s > $signed({2'b00, {DW{1'b1}}})) begin
            diff_c = {DW{1'b1}};
        end else begin
            diff_c = diff_s[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_seed <= s_axis_tdata[DW-1:0];
        end
        if (ctrl.idx_mul) begin
            r_qp <= QP_W'(r_last) * QP_W'(RECIP);
        end
        if (ctrl.idx_q) begin
            r_q0 <= q0;
            r_qd <= DW'(64'(q0) * 64'(IDX_DIV));
        end
        if (ctrl.idx_fix) begin
            r_idx <= (32'(q) >= 32'(TABLE_DEPTH)) ? IDX_W'(TABLE_DEPTH - 1) : IDX_W'(q);
        end
        if (ctrl.wb2) begin
            r_negc <= SPAN1 - {1'b0, y2};
        end
        if (ctrl.out_ld && out_free) begin
            r_sample <= ({1'b0, r_last} > SAMPLE_MAX) ? SAMPLE_MAX[DW-1:0] : r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op        <= 1'b0;
            r_g1        <= DW'(1);
            r_g2        <= GEN2_INIT;
            r_last      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_op <= s_axis_tuser[0];
            end
            if (ctrl.ld_seed) begin
                r_g1  <= (r_seed == '0) ? DW'(1) : r_seed;
                r_g2  <= (r_seed == '0) ? DW'(1) : r_seed;
                r_cnt <= CNT_W'(TABLE_DEPTH + WARMUP_EXTRA - 1);
            end
            if (ctrl.cnt_dec) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (ctrl.wb1) begin
                r_g1 <= y1;
            end
            if (ctrl.wb2) begin
                r_g2 <= y2;
            end
            // The final warm-up value is table entry zero and seeds the index.
            if (ctrl.warm_wr && (r_cnt == '0)) begin
                r_last <= y1;
            end
            if (ctrl.diff) begin
                r_last <= diff_c;
            end
            if (ctrl.out_ld && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_sample};

    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while an item is in progress");

    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_sample != '0 && {1'b0, r_sample} <= SAMPLE_MAX))
        else $error("sample outside its range");

    a_gen2_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(ctrl.wb2) |-> ({1'b0, r_g2} < MOD2))
        else $error("second generator not reduced below its modulus");

    a_gen1_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(ctrl.wb1) |-> ({1'b0, r_g1} < MOD1))
        else $error("first generator not reduced below its modulus");

endmodule

/* bench/combined_lcg_shuffle_rng_top_tb.sv */
// Self-checking bench for combined_lcg_shuffle_rng_top: a directed table, then random
// draws and reseeds under varying stream back-pressure, checked against a local model.
// Depends on the top level and everything it instantiates.

module combined_lcg_shuffle_rng_top_tb;

    localparam int          TABLE_DEPTH = 32;
    localparam longint      GEN1_MOD    = 64'd2147483563;
    localparam longint      GEN2_MOD    = 64'd2147483399;
    localparam longint      GEN1_MUL    = 64'd40014;
    localparam longint      GEN2_MUL    = 64'd40692;
    localparam longint      GEN1_SPAN   = GEN1_MOD - 1;
    localparam longint      PICK_DIV    = 1 + GEN1_SPAN / TABLE_DEPTH;
    localparam logic [30:0] SAMPLE_CLAMP = 31'd2147483305;
    localparam longint      WORD_MAX    = 64'h7FFF_FFFF;
    localparam int          WARMUP_STEPS = TABLE_DEPTH + 8;
    localparam int          PHASE_ITEMS = 333;
    localparam int          HOLD_CYCLES = 120;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          NUM_ROWS    = 20;

    typedef enum logic {
        OP_DRAW   = 1'b0,
        OP_RESEED = 1'b1
    } t_rng_op;

    typedef struct packed {
        t_rng_op     op;
        logic [30:0] seed;
        logic        known;
        logic [30:0] sample;
    } t_stim_row;

    // Rows with known set carry a sample worked out by hand: the first draw out of
    // reset, and a reseed that parks the first generator at zero.
    t_stim_row directed_rows [0:NUM_ROWS-1] = '{
        '{OP_DRAW,   31'd0,          1'b1, 31'd1407495835},
        '{OP_DRAW,   31'd0,          1'b0, 31'd0},
        '{OP_RESEED, 31'd0,          1'b0, 31'd0},
        '{OP_DRAW,   31'd0,          1'b0, 31'd0},
        '{OP_RESEED, 31'd1,          1'b0, 31'd0},
        '{OP_DRAW,   31'd0,          1'b0, 31'd0},
        '{OP_RESEED, 31'd2147483563, 1'b1, 31'd2140810074},
        '{OP_DRAW,   31'd0,          1'b0, 31'd0},
        '{OP_RESEED, 31'd2147483399, 1'b0, 31'd0},
        '{OP_DRAW,   31'd0,          1'b0, 31'd0},
        '{OP_RESEED, 31'h7FFF_FFFF,  1'b0, 31'd0},
        '{OP_DRAW,   31'h7FFF_FFFF,  1'b0, 31'd0},
        '{OP_RESEED, 31'h5555_5555,  1'b0, 31'd0},
        '{OP_RESEED, 31'h2AAA_AAAA,  1'b0, 31'd0},
        '{OP_DRAW,   31'd0,          1'b0, 31'd0},
        '{OP_RESEED, 31'd2147483562, 1'b0, 31'd0},
        '{OP_RESEED, 31'd2147483400, 1'b0, 31'd0},
        '{OP_DRAW,   31'h1234_5678,  1'b0, 31'd0},
        '{OP_DRAW,   31'd0,          1'b0, 31'd0},
        '{OP_RESEED, 31'd12345,      1'b0, 31'd0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // [30:0] seed, [31] zero
    logic [0:0]  s_axis_tuser = '0;    // [0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [30:0] sample, [31] zero

    logic [30:0] gen1_state;
    logic [30:0] gen2_state;
    logic [30:0] last_draw;
    logic [30:0] shuffle_tbl [0:TABLE_DEPTH-1];

    logic [30:0] pending_samples [$];
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          holds_asked = 0;
    int          holds_served = 0;
    int          hold_left = 0;

    combined_lcg_shuffle_rng_top #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [30:0] mcg_next(input logic [30:0] x, input longint mul,
                                             input longint modulus);
        longint unsigned prod;
        prod = longint'(x) * mul;
        return 31'(prod % modulus);
    endfunction

    task automatic init_generator();
        gen1_state = 31'd1;
        gen2_state = 31'd123456789;
        last_draw  = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) shuffle_tbl[k] = '0;
    endtask

    task automatic next_sample(input t_rng_op op, input logic [30:0] seed,
                               output logic [30:0] sample);
        longint diff;
        int     pick;
        if (op == OP_RESEED) begin
            gen1_state = (seed == 0) ? 31'd1 : seed;
            gen2_state = gen1_state;
            for (int w = WARMUP_STEPS - 1; w >= 0; w--) begin
                gen1_state = mcg_next(gen1_state, GEN1_MUL, GEN1_MOD);
                if (w < TABLE_DEPTH) shuffle_tbl[w] = gen1_state;
            end
            last_draw = shuffle_tbl[0];
        end
        gen1_state = mcg_next(gen1_state, GEN1_MUL, GEN1_MOD);
        gen2_state = mcg_next(gen2_state, GEN2_MUL, GEN2_MOD);
        pick = int'(longint'(last_draw) / PICK_DIV);
        if (pick >= TABLE_DEPTH) pick = TABLE_DEPTH - 1;
        diff = longint'(shuffle_tbl[pick]) - longint'(gen2_state);
        shuffle_tbl[pick] = gen1_state;
        if (diff < 1) diff += GEN1_SPAN;
        if (diff < 1) diff = 1;
        if (diff > WORD_MAX) diff = WORD_MAX;
        last_draw = 31'(diff);
        sample = (last_draw > SAMPLE_CLAMP) ? SAMPLE_CLAMP : last_draw;
    endtask

    // Offers one item after a random gap and returns just after its transfer edge.
    task automatic send_item(input t_rng_op op, input logic [30:0] seed,
                             input logic known, input logic [30:0] known_sample);
        logic [30:0] predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, seed};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        next_sample(op, seed, predicted);
        pending_samples.push_back(known ? known_sample : predicted);
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [30:0] random_seed();
        case ($urandom_range(0, 7))
            0:       return 31'($urandom_range(0, 3));
            1:       return 31'($urandom_range(2147483395, 2147483647));
            default: return 31'($urandom);
        endcase
    endfunction

    // Receiver: random back-pressure, plus long hold-offs asked for by the stimulus.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (holds_served != holds_asked) begin
            holds_served  <= holds_served + 1;
            hold_left     <= HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        logic [30:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_samples.size() == 0) begin
                $error("sample: unexpected transfer, actual %0d", m_axis_tdata[30:0]);
                error_count++;
            end else begin
                want = pending_samples.pop_front();
                if (m_axis_tdata[30:0] !== want) begin
                    $error("sample mismatch: expected %0d, actual %0d",
                           want, m_axis_tdata[30:0]);
                    error_count++;
                end
            end
        end
    end

    initial begin
        t_rng_op op;
        init_generator();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 18;
        recv_idle_pct = 67;
        for (int r = 0; r < NUM_ROWS; r++) begin
            send_item(directed_rows[r].op, directed_rows[r].seed,
                      directed_rows[r].known, directed_rows[r].sample);
        end

        for (int ph = 0; ph < 3; ph++) begin
            // The sender pauses here until every result sent so far is out.
            s_axis_tvalid <= 1'b0;
            wait_drained();
            @(posedge i_clk);
            send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 67 : 0;
            recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 18 : 0;
            if (ph == 2) holds_asked++;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (ph == 0 && i == 100) holds_asked++;
                op = ($urandom_range(0, 11) == 0) ? OP_RESEED : OP_DRAW;
                send_item(op, random_seed(), 1'b0, '0);
            end
        end
        s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_samples.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

/* combined_lcg_shuffle_rng_top.f */
rtl/core/clsr_pkg.sv
rtl/core/clsr_mcg.sv
rtl/core/clsr_table.sv
rtl/core/clsr_ucode.sv
rtl/core/combined_lcg_shuffle_rng_top.sv
bench/combined_lcg_shuffle_rng_top_tb.sv
